FILE: rtl/tmdu_pkg.sv
// Shared types, codes and sizes for the tape machine data unit.
// No dependencies; every other file but tmdu_ram imports this package.
package tmdu_pkg;

	localparam int TAPE_DEPTH = 4096;
	localparam int ADDR_W     = $clog2(TAPE_DEPTH);
	localparam int PTR_W      = 12;
	localparam int CNT_W      = 16;
	localparam int BYTE_W     = 8;
	localparam int TYPE_W     = 3;
	localparam int STAT_W     = 2;
	localparam int KIND_W     = 3;
	localparam int APB_AW     = 3;
	localparam int APB_DW     = 32;
	localparam int Q_DEPTH    = 2;
	localparam int Q_IDX_W    = $clog2(Q_DEPTH);

	// request codes on the input channel
	localparam logic [TYPE_W-1:0] REQ_LEFT   = 3'd0;
	localparam logic [TYPE_W-1:0] REQ_RIGHT  = 3'd1;
	localparam logic [TYPE_W-1:0] REQ_INC    = 3'd2;
	localparam logic [TYPE_W-1:0] REQ_DEC    = 3'd3;
	localparam logic [TYPE_W-1:0] REQ_OUTPUT = 3'd4;
	localparam logic [TYPE_W-1:0] REQ_INPUT  = 3'd5;

	// result status
	localparam logic [STAT_W-1:0] ST_OK        = 2'd0;
	localparam logic [STAT_W-1:0] ST_UNDERFLOW = 2'd1;
	localparam logic [STAT_W-1:0] ST_OVERFLOW  = 2'd2;
	localparam logic [STAT_W-1:0] ST_INPUT_ERR = 2'd3;

	// decoded command kinds handed from front to back
	localparam logic [KIND_W-1:0] K_NOP   = 3'd0;
	localparam logic [KIND_W-1:0] K_LEFT  = 3'd1;
	localparam logic [KIND_W-1:0] K_RIGHT = 3'd2;
	localparam logic [KIND_W-1:0] K_ADD   = 3'd3;
	localparam logic [KIND_W-1:0] K_STORE = 3'd4;
	localparam logic [KIND_W-1:0] K_EMIT  = 3'd5;
	localparam logic [KIND_W-1:0] K_ERR   = 3'd6;

	// register indexes (byte address / 4)
	localparam logic CFG_OUT_EN = 1'b0;
	localparam logic CFG_IN_EN  = 1'b1;

	typedef struct packed {
		logic [KIND_W-1:0] kind;
		logic [CNT_W-1:0]  count;  // pointer distance or emit repeats
		logic [BYTE_W-1:0] value;  // cell delta or byte to store
	} cmd_t;

endpackage

FILE: rtl/tmdu_req_if.sv
// Request channel of the tape machine data unit: valid/ready plus payload.
// Depends on tmdu_pkg.
interface tmdu_req_if;
	import tmdu_pkg::*;

	logic              valid;
	logic              ready;
	logic [TYPE_W-1:0] req_type;
	logic [CNT_W-1:0]  repeat_count;
	logic [BYTE_W-1:0] input_byte;
	logic              input_at_end;
	logic              input_failed;

	modport source (output valid, req_type, repeat_count, input_byte, input_at_end,
		input_failed, input ready);
	modport sink (input valid, req_type, repeat_count, input_byte, input_at_end,
		input_failed, output ready);
endinterface

FILE: rtl/tmdu_rsp_if.sv
// Result channel of the tape machine data unit: valid/ready plus payload.
// Depends on tmdu_pkg.
interface tmdu_rsp_if;
	import tmdu_pkg::*;

	logic              valid;
	logic              ready;
	logic [STAT_W-1:0] status;
	logic [BYTE_W-1:0] cell_value;
	logic              cell_nonzero;
	logic [PTR_W-1:0]  pointer_now;
	logic              emit_valid;
	logic [BYTE_W-1:0] emit_byte;
	logic [CNT_W-1:0]  emit_repeat;

	modport source (output valid, status, cell_value, cell_nonzero, pointer_now,
		emit_valid, emit_byte, emit_repeat, input ready);
	modport sink (input valid, status, cell_value, cell_nonzero, pointer_now,
		emit_valid, emit_byte, emit_repeat, output ready);
endinterface

FILE: rtl/tmdu_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Read during write to the same address returns the old contents.
module tmdu_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

FILE: rtl/tmdu_front.sv
// Front end: configuration registers and request decode into commands.
// Depends on tmdu_pkg and tmdu_req_if.
module tmdu_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [tmdu_pkg::APB_AW-1:0]   paddr,
	input  logic [tmdu_pkg::APB_DW-1:0]   pwdata,
	output logic [tmdu_pkg::APB_DW-1:0]   prdata,
	output logic                          pready,
	tmdu_req_if.sink                      req,
	input  logic                          q_full,
	input  logic                          clearing,
	output logic                          push,
	output tmdu_pkg::cmd_t                push_cmd
);
	import tmdu_pkg::*;

	logic out_en_q;
	logic in_en_q;
	logic cfg_wr;
	logic cfg_idx;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite;
	assign cfg_idx = paddr[APB_AW-1];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_en_q <= 1'b1;
			in_en_q  <= 1'b1;
		end else if (cfg_wr) begin
			case (cfg_idx)
				CFG_OUT_EN: out_en_q <= pwdata[0];
				CFG_IN_EN:  in_en_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			CFG_OUT_EN: prdata = APB_DW'(out_en_q);
			CFG_IN_EN:  prdata = APB_DW'(in_en_q);
			default:    prdata = '0;
		endcase
	end

	assign req.ready = !q_full && !clearing;
	assign push      = req.valid && req.ready;

	// resolve enables and input-source flags here so the back end only
	// sees pointer moves, cell adds, stores, emits, no-ops and faults
	always_comb begin
		push_cmd.kind  = K_NOP;
		push_cmd.count = req.repeat_count;
		push_cmd.value = '0;
		case (req.req_type)
			REQ_LEFT:  push_cmd.kind = K_LEFT;
			REQ_RIGHT: push_cmd.kind = K_RIGHT;
			REQ_INC: begin
				push_cmd.kind  = K_ADD;
				push_cmd.value = req.repeat_count[BYTE_W-1:0];
			end
			REQ_DEC: begin
				push_cmd.kind  = K_ADD;
				push_cmd.value = ~req.repeat_count[BYTE_W-1:0] + 8'd1;
			end
			REQ_OUTPUT: begin
				if (out_en_q && (req.repeat_count != '0)) begin
					push_cmd.kind = K_EMIT;
				end
			end
			REQ_INPUT: begin
				if (!in_en_q) begin
					push_cmd.kind = K_STORE;
				end else if (req.repeat_count == '0) begin
					push_cmd.kind = K_NOP;
				end else if (req.input_at_end) begin
					push_cmd.kind = K_STORE;
				end else if (req.input_failed) begin
					push_cmd.kind = K_ERR;
				end else begin
					push_cmd.kind  = K_STORE;
					push_cmd.value = req.input_byte;
				end
			end
			default: push_cmd.kind = K_NOP;
		endcase
	end
endmodule

FILE: rtl/tmdu_queue.sv
// Short command queue between front and back ends.
// Depends on tmdu_pkg.
module tmdu_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           push,
	input  tmdu_pkg::cmd_t push_cmd,
	output logic           full,
	input  logic           pop,
	output logic           head_v,
	output tmdu_pkg::cmd_t head
);
	import tmdu_pkg::*;

	cmd_t               entry_q [Q_DEPTH];
	logic [Q_IDX_W-1:0] wr_ptr_q;
	logic [Q_IDX_W-1:0] rd_ptr_q;
	logic [Q_IDX_W:0]   cnt_q;

	assign full   = (cnt_q == (Q_IDX_W+1)'(Q_DEPTH));
	assign head_v = (cnt_q != '0);
	assign head   = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_cmd;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end
endmodule

FILE: rtl/tmdu_back.sv
// Back end: data pointer, tape read-modify-write with forwarding, result register.
// Depends on tmdu_pkg, tmdu_rsp_if and tmdu_ram.
module tmdu_back (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           head_v,
	input  tmdu_pkg::cmd_t head,
	output logic           pop,
	output logic           clearing,
	tmdu_rsp_if.source     rsp
);
	import tmdu_pkg::*;

	logic [ADDR_W-1:0] ptr_q;
	logic [ADDR_W:0]   clr_cnt_q;

	// execute stage
	logic              v_s1;
	logic [KIND_W-1:0] kind_s1;
	logic [CNT_W-1:0]  count_s1;
	logic [BYTE_W-1:0] value_s1;
	logic [ADDR_W-1:0] ptr_s1;
	logic [STAT_W-1:0] status_s1;
	logic              fwd_s1;
	logic [BYTE_W-1:0] fwd_val_s1;

	// result register
	logic              out_v_q;
	logic [STAT_W-1:0] status_q;
	logic [BYTE_W-1:0] cell_q;
	logic              nonzero_q;
	logic [PTR_W-1:0]  pointer_q;
	logic              emit_v_q;
	logic [BYTE_W-1:0] emit_byte_q;
	logic [CNT_W-1:0]  emit_rep_q;

	logic              fire_s1;
	logic              wr_s1;
	logic [BYTE_W-1:0] rd_data;
	logic [BYTE_W-1:0] cell_in;
	logic [BYTE_W-1:0] cell_new;
	logic [ADDR_W-1:0] ptr_nxt;
	logic [STAT_W-1:0] status_nxt;
	logic [CNT_W:0]    right_sum;
	logic              under;
	logic              over;
	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	logic [BYTE_W-1:0] ram_wdata;

	assign clearing = !clr_cnt_q[ADDR_W];
	assign fire_s1  = v_s1 && (!out_v_q || rsp.ready);
	assign pop      = head_v && !clearing && (!v_s1 || fire_s1);

	// pointer update, one move per cycle while commands are popped
	assign right_sum = (CNT_W+1)'(ptr_q) + (CNT_W+1)'(head.count);
	assign under     = head.count > CNT_W'(ptr_q);
	assign over      = right_sum >= (CNT_W+1)'(TAPE_DEPTH);

	always_comb begin
		ptr_nxt    = ptr_q;
		status_nxt = ST_OK;
		case (head.kind)
			K_LEFT: begin
				if (under) begin
					status_nxt = ST_UNDERFLOW;
				end else begin
					ptr_nxt = ptr_q - head.count[ADDR_W-1:0];
				end
			end
			K_RIGHT: begin
				if (over) begin
					status_nxt = ST_OVERFLOW;
				end else begin
					ptr_nxt = right_sum[ADDR_W-1:0];
				end
			end
			K_ERR:   status_nxt = ST_INPUT_ERR;
			default: ;
		endcase
	end

	// cell stage
	assign cell_in = fwd_s1 ? fwd_val_s1 : rd_data;
	assign wr_s1   = (kind_s1 == K_ADD) || (kind_s1 == K_STORE);

	always_comb begin
		case (kind_s1)
			K_ADD:   cell_new = cell_in + value_s1;
			K_STORE: cell_new = value_s1;
			default: cell_new = cell_in;
		endcase
	end

	assign ram_we    = clearing || (fire_s1 && wr_s1);
	assign ram_waddr = clearing ? clr_cnt_q[ADDR_W-1:0] : ptr_s1;
	assign ram_wdata = clearing ? '0 : cell_new;

	tmdu_ram #(
		.WIDTH(BYTE_W),
		.DEPTH(TAPE_DEPTH)
	) u_tape (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (pop),
		.raddr(ptr_nxt),
		.rdata(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_cnt_q <= '0;
			ptr_q     <= '0;
			v_s1      <= 1'b0;
			fwd_s1    <= 1'b0;
			out_v_q   <= 1'b0;
		end else begin
			if (clearing) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (pop) begin
				ptr_q <= ptr_nxt;
				// the read issued now misses a write landing on the same edge
				fwd_s1 <= fire_s1 && wr_s1 && (ptr_s1 == ptr_nxt);
			end else if (fire_s1) begin
				fwd_s1 <= 1'b0;
			end
			if (pop) begin
				v_s1 <= 1'b1;
			end else if (fire_s1) begin
				v_s1 <= 1'b0;
			end
			if (fire_s1) begin
				out_v_q <= 1'b1;
			end else if (rsp.ready) begin
				out_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			kind_s1    <= head.kind;
			count_s1   <= head.count;
			value_s1   <= head.value;
			ptr_s1     <= ptr_nxt;
			status_s1  <= status_nxt;
			fwd_val_s1 <= cell_new;
		end
		if (fire_s1) begin
			status_q    <= status_s1;
			cell_q      <= cell_new;
			nonzero_q   <= (cell_new != '0);
			pointer_q   <= PTR_W'(ptr_s1);
			emit_v_q    <= (kind_s1 == K_EMIT);
			emit_byte_q <= (kind_s1 == K_EMIT) ? cell_in : '0;
			emit_rep_q  <= (kind_s1 == K_EMIT) ? count_s1 : '0;
		end
	end

	assign rsp.valid        = out_v_q;
	assign rsp.status       = status_q;
	assign rsp.cell_value   = cell_q;
	assign rsp.cell_nonzero = nonzero_q;
	assign rsp.pointer_now  = pointer_q;
	assign rsp.emit_valid   = emit_v_q;
	assign rsp.emit_byte    = emit_byte_q;
	assign rsp.emit_repeat  = emit_rep_q;

	a_no_pop_clear: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> !pop)
		else $error("command taken during tape clear");

	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s1 |-> v_s1)
		else $error("forward flag without command in execute stage");

	a_ptr_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!pop |=> ptr_q == $past(ptr_q))
		else $error("pointer moved without a command");

	a_fault_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && (status_nxt == ST_UNDERFLOW || status_nxt == ST_OVERFLOW))
		|=> ptr_q == $past(ptr_q))
		else $error("pointer moved on a faulting move");
endmodule

FILE: rtl/tape_machine_data_unit_core.sv
// Top level of the tape machine data unit: APB registers, front, queue, back.
// Depends on tmdu_pkg, tmdu_req_if, tmdu_rsp_if, tmdu_front, tmdu_queue, tmdu_back.
//
// Data side of a tape machine running run-length-coded operations on a
// 4096-byte tape. Each request (left, right, increment, decrement, output,
// input) yields exactly one result with status, current cell, nonzero flag,
// pointer and any output byte with its repeat count. After reset the tape
// is swept to zero one cell a cycle, so req.ready stays low until the whole
// tape is cleared; APB writes are taken throughout. Once cleared the unit
// takes one request per cycle while results are taken: the front decodes a
// request into a command, a two-entry queue holds it, and the back moves the
// pointer as the command leaves the queue, launches the tape read at the new
// position and does the cell update in the execute stage, forwarding the
// previous write when both hit the same cell. A result passes through the
// queue and the execute stage into an output register; the only serial
// path is the 12-bit pointer update, one per cycle while commands are popped.
// Registers: output_enable at byte 0 and input_enable at byte 4, bit 0 of
// each, both 1 after reset; change them only while no request is in flight.
module tape_machine_data_unit_core (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tmdu_pkg::APB_AW-1:0] paddr,
	input  logic [tmdu_pkg::APB_DW-1:0] pwdata,
	output logic [tmdu_pkg::APB_DW-1:0] prdata,
	output logic                        pready,
	tmdu_req_if.sink                    req,
	tmdu_rsp_if.source                  rsp
);
	import tmdu_pkg::*;

	logic push;
	logic q_full;
	logic pop;
	logic head_v;
	logic clearing;
	cmd_t push_cmd;
	cmd_t head;

	// decode and config; stalls only on a full queue or the tape clear
	tmdu_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.req     (req),
		.q_full  (q_full),
		.clearing(clearing),
		.push    (push),
		.push_cmd(push_cmd)
	);

	tmdu_queue u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.push_cmd(push_cmd),
		.full    (q_full),
		.pop     (pop),
		.head_v  (head_v),
		.head    (head)
	);

	// pointer, tape and result register
	tmdu_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head_v  (head_v),
		.head    (head),
		.pop     (pop),
		.clearing(clearing),
		.rsp     (rsp)
	);
endmodule
